>>> rtl/core/tbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbs_pkg;

	// block geometry
	localparam int BAND_ROWS   = 8;
	localparam int BLOCK_BYTES = 16;
	localparam int BLOCK_WORDS = BLOCK_BYTES / 4;
	localparam int ROW_W       = $clog2(BAND_ROWS + 1);

	// parameter defaults
	localparam int MAX_ROW_BYTES_DEF = 2048;
	localparam int MAX_BANDS_DEF     = 64;

	// register file
	localparam int ROW_BYTES_W  = 12;
	localparam int BAND_CNT_W   = 7;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = ROW_BYTES_W;
	localparam int WORD_W       = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT = 1'b1;

	localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST  = 12'd2048;
	localparam logic [BAND_CNT_W-1:0]  BAND_COUNT_RST = 7'd64;
	localparam logic [BAND_CNT_W-1:0]  BAND_CNT_SAT   = 7'd127;

	// item kinds on s_tuser
	localparam logic OP_DATA  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// fill side status seen by the emit side
	typedef struct packed {
		logic done;   // band completes with this transfer
		logic half;   // half currently being filled
	} fill_stat_t;

	// read request towards the output stage
	typedef struct packed {
		logic en;
		logic last;
	} rd_req_t;

endpackage

`default_nettype wire

>>> rtl/core/texture_block_swizzle_unit.sv
// a read word passes the buffer's read register, then the output register, to m_tdata
// throughput: one item per cycle while s_tready is high; a transfer writes and reads at most
//   one word each of the dual-ported ping-pong band buffer, the first band gives no output
// a configuration write holds s_tready low in its own cycle and the next one,
//   while the fill row and column are rebuilt from the linear fill position
// reset: asynchronous, clears counters and handshake state; buffer contents undefined
`timescale 1ns / 1ps
`default_nettype none

module texture_block_swizzle_unit #(
	parameter int MAX_ROW_BYTES = tbs_pkg::MAX_ROW_BYTES_DEF,
	parameter int MAX_BANDS     = tbs_pkg::MAX_BANDS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// register write port
	input  wire logic                          cfg_we,
	input  wire logic [tbs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tbs_pkg::CFG_DATA_W-1:0] cfg_data,
	// linear input stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [tbs_pkg::WORD_W-1:0]    s_tdata,   // [31:0] data_word
	input  wire logic                          s_tuser,   // [0] operation (0 data, 1 drain)
	// swizzled output stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [tbs_pkg::WORD_W-1:0]    m_tdata,   // [31:0] out_word
	output logic                               m_tlast    // last_word
);

	localparam int ROW_SPAN   = MAX_ROW_BYTES / 4;
	localparam int HALF_WORDS = tbs_pkg::BAND_ROWS * ROW_SPAN;
	localparam int IW         = $clog2(HALF_WORDS);
	localparam int CW         = IW + 1;
	localparam int AW         = IW + 1;
	localparam int RB_W       = $clog2(MAX_ROW_BYTES + 1);
	localparam int CMP_W      = (RB_W > tbs_pkg::ROW_BYTES_W) ? RB_W : tbs_pkg::ROW_BYTES_W;
	localparam int BC_W       = 9;

	// configuration registers
	logic [tbs_pkg::ROW_BYTES_W-1:0] row_bytes_q;
	logic [tbs_pkg::BAND_CNT_W-1:0]  band_count_q;
	logic                            resync_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q  <= tbs_pkg::ROW_BYTES_RST;
			band_count_q <= tbs_pkg::BAND_COUNT_RST;
			resync_q     <= 1'b0;
		end else begin
			resync_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_index)
					tbs_pkg::CFG_ROW_BYTES:  row_bytes_q  <= cfg_data;
					tbs_pkg::CFG_BAND_COUNT: band_count_q <= cfg_data[tbs_pkg::BAND_CNT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// effective row width clamped to one block .. buffer row
	logic [CMP_W-1:0]                rb_wide;
	logic [RB_W-1:0]                 rb_eff;
	logic [CW-1:0]                   wpr;
	logic [CW-1:0]                   used;
	logic [CW-1:0]                   band_words;
	logic [CW-1:0]                   emit_words;
	logic [tbs_pkg::BAND_CNT_W-1:0]  bands;

	always_comb begin
		rb_wide = CMP_W'(row_bytes_q);
		if (rb_wide < CMP_W'(tbs_pkg::BLOCK_BYTES)) begin
			rb_eff = RB_W'(tbs_pkg::BLOCK_BYTES);
		end else if (rb_wide > CMP_W'(MAX_ROW_BYTES)) begin
			rb_eff = RB_W'(MAX_ROW_BYTES);
		end else begin
			rb_eff = RB_W'(rb_wide);
		end
	end

	// words per row, kept words per row (whole blocks only), band sizes
	assign wpr        = CW'(rb_eff >> 2);
	assign used       = CW'((rb_eff >> 4) << 2);
	assign band_words = wpr << 3;
	assign emit_words = used << 3;

	// band count saturates at MAX_BANDS
	assign bands = (BC_W'(band_count_q) > BC_W'(MAX_BANDS))
		? tbs_pkg::BAND_CNT_W'(MAX_BANDS) : band_count_q;

	// handshake
	logic space;
	logic accept;
	logic step;

	assign s_tready = space && !resync_q && !cfg_we;
	assign accept   = s_tvalid && s_tready;
	assign step     = accept && (s_tuser == tbs_pkg::OP_DATA);

	tbs_pkg::fill_stat_t         stat;
	tbs_pkg::rd_req_t            rd_req;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [tbs_pkg::WORD_W-1:0]  wr_data;
	logic [AW-1:0]               rd_addr;
	logic [tbs_pkg::WORD_W-1:0]  rd_data;

	// fill side writes the incoming band into one half
	tbs_fill #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES)
	) u_fill (
		.clk       (clk),
		.arst_n    (arst_n),
		.resync    (resync_q),
		.step      (step),
		.wpr       (wpr),
		.used      (used),
		.band_words(band_words),
		.bands     (bands),
		.word      (s_tdata),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.stat      (stat)
	);

	// emit side walks the other half in block order, one word per transfer
	tbs_emit #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.stat      (stat),
		.emit_words(emit_words),
		.bands     (bands),
		.rd_req    (rd_req),
		.rd_addr   (rd_addr)
	);

	// halves never overlap between a read and a write of the same transfer
	tbs_buffer #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES)
	) u_buffer (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_req.en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// read stage plus output register
	tbs_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_req  (rd_req),
		.rd_data (rd_data),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.space   (space)
	);

endmodule

`default_nettype wire

>>> rtl/core/tbs_buffer.sv
`timescale 1ns / 1ps
`default_nettype none

module tbs_buffer #(
	parameter int MAX_ROW_BYTES = tbs_pkg::MAX_ROW_BYTES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      wr_en,
	input  wire logic [$clog2(2 * tbs_pkg::BAND_ROWS * (MAX_ROW_BYTES / 4))-1:0] wr_addr,
	input  wire logic [tbs_pkg::WORD_W-1:0] wr_data,
	input  wire logic                      rd_en,
	input  wire logic [$clog2(2 * tbs_pkg::BAND_ROWS * (MAX_ROW_BYTES / 4))-1:0] rd_addr,
	output logic      [tbs_pkg::WORD_W-1:0] rd_data
);

	localparam int DEPTH = 2 * tbs_pkg::BAND_ROWS * (MAX_ROW_BYTES / 4);

	// ping-pong band store, one write and one read port
	logic [tbs_pkg::WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/tbs_fill.sv
`timescale 1ns / 1ps
`default_nettype none

module tbs_fill #(
	parameter int MAX_ROW_BYTES = tbs_pkg::MAX_ROW_BYTES_DEF,
	localparam int ROW_SPAN   = MAX_ROW_BYTES / 4,
	localparam int HALF_WORDS = tbs_pkg::BAND_ROWS * ROW_SPAN,
	localparam int IW         = $clog2(HALF_WORDS),
	localparam int CW         = IW + 1,
	localparam int AW         = IW + 1
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            resync,
	input  wire logic                            step,
	input  wire logic [CW-1:0]                   wpr,
	input  wire logic [CW-1:0]                   used,
	input  wire logic [CW-1:0]                   band_words,
	input  wire logic [tbs_pkg::BAND_CNT_W-1:0]  bands,
	input  wire logic [tbs_pkg::WORD_W-1:0]      word,
	output logic                                 wr_en,
	output logic      [AW-1:0]                   wr_addr,
	output logic      [tbs_pkg::WORD_W-1:0]      wr_data,
	output tbs_pkg::fill_stat_t                  stat
);

	localparam int TW = CW + 3;

	logic [IW-1:0]                  idx_q;
	logic [tbs_pkg::ROW_W-1:0]      row_q;
	logic [IW-1:0]                  col_q;
	logic                           half_q;
	logic [tbs_pkg::BAND_CNT_W-1:0] filled_q;

	logic                           live;
	logic [CW-1:0]                  idx_next;
	logic [CW-1:0]                  col_next;
	logic                           wrap;
	logic                           done;
	logic [tbs_pkg::ROW_W-1:0]      rs_row;
	logic [IW-1:0]                  rs_col;

	assign live     = step && (filled_q < bands);
	assign idx_next = CW'(idx_q) + CW'(1);
	assign col_next = CW'(col_q) + CW'(1);
	assign wrap     = col_next >= wpr;
	assign done     = live && (idx_next >= band_words);

	assign wr_en   = live && (row_q < tbs_pkg::ROW_W'(tbs_pkg::BAND_ROWS)) && (CW'(col_q) < used);
	assign wr_addr = (half_q ? AW'(HALF_WORDS) : '0)
		+ AW'(row_q[tbs_pkg::ROW_W-2:0]) * AW'(ROW_SPAN) + AW'(col_q);
	assign wr_data = word;

	assign stat.done = done;
	assign stat.half = half_q;

	// recover row and column from the linear fill position after a register change
	always_comb begin
		logic [TW-1:0] thr;
		logic [TW-1:0] base;
		rs_row = '0;
		base   = '0;
		for (int k = 1; k <= tbs_pkg::BAND_ROWS; k++) begin
			thr = TW'(k) * TW'(wpr);
			if (TW'(idx_q) >= thr) begin
				rs_row = tbs_pkg::ROW_W'(k);
				base   = thr;
			end
		end
		rs_col = IW'(TW'(idx_q) - base);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
			half_q   <= 1'b0;
			filled_q <= '0;
		end else if (resync) begin
			row_q <= rs_row;
			col_q <= rs_col;
		end else if (live) begin
			if (done) begin
				idx_q    <= '0;
				row_q    <= '0;
				col_q    <= '0;
				half_q   <= ~half_q;
				filled_q <= filled_q + tbs_pkg::BAND_CNT_W'(1);
			end else begin
				idx_q <= IW'(idx_next);
				if (wrap) begin
					col_q <= '0;
					row_q <= row_q + tbs_pkg::ROW_W'(1);
				end else begin
					col_q <= IW'(col_next);
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/tbs_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module tbs_emit #(
	parameter int MAX_ROW_BYTES = tbs_pkg::MAX_ROW_BYTES_DEF,
	localparam int ROW_SPAN   = MAX_ROW_BYTES / 4,
	localparam int HALF_WORDS = tbs_pkg::BAND_ROWS * ROW_SPAN,
	localparam int IW         = $clog2(HALF_WORDS),
	localparam int CW         = IW + 1,
	localparam int AW         = IW + 1
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           accept,
	input  wire tbs_pkg::fill_stat_t            stat,
	input  wire logic [CW-1:0]                  emit_words,
	input  wire logic [tbs_pkg::BAND_CNT_W-1:0] bands,
	output tbs_pkg::rd_req_t                    rd_req,
	output logic      [AW-1:0]                  rd_addr
);

	// block of 8 rows x 4 words: low two bits pick the word, next three the row
	localparam int BLK_SHIFT = $clog2(tbs_pkg::BAND_ROWS * tbs_pkg::BLOCK_WORDS);
	localparam int WRD_BITS  = $clog2(tbs_pkg::BLOCK_WORDS);

	logic [IW-1:0]                  emit_q;
	logic                           pending_q;
	logic [tbs_pkg::BAND_CNT_W-1:0] emitted_q;

	logic                           end_w;
	logic [2:0]                     row;
	logic [IW-1:0]                  col;

	assign end_w = (CW'(emit_q) + CW'(1)) >= emit_words;
	assign row   = emit_q[BLK_SHIFT-1:WRD_BITS];
	assign col   = ((emit_q >> BLK_SHIFT) << WRD_BITS) | IW'(emit_q[WRD_BITS-1:0]);

	assign rd_req.en   = accept && pending_q;
	assign rd_req.last = end_w
		&& ((tbs_pkg::BAND_CNT_W + 1)'(emitted_q) + (tbs_pkg::BAND_CNT_W + 1)'(1)
			>= (tbs_pkg::BAND_CNT_W + 1)'(bands));

	// the pending band sits in the half not being filled
	assign rd_addr = (stat.half ? '0 : AW'(HALF_WORDS))
		+ AW'(row) * AW'(ROW_SPAN) + AW'(col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q    <= '0;
			pending_q <= 1'b0;
			emitted_q <= '0;
		end else begin
			if (rd_req.en) begin
				if (end_w) begin
					pending_q <= 1'b0;
					emit_q    <= '0;
					if (emitted_q < tbs_pkg::BAND_CNT_SAT) begin
						emitted_q <= emitted_q + tbs_pkg::BAND_CNT_W'(1);
					end
				end else begin
					emit_q <= emit_q + IW'(1);
				end
			end
			// a freshly completed band takes over
			if (stat.done) begin
				pending_q <= 1'b1;
				emit_q    <= '0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/tbs_out.sv
`timescale 1ns / 1ps
`default_nettype none

module tbs_out (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire tbs_pkg::rd_req_t           rd_req,
	input  wire logic [tbs_pkg::WORD_W-1:0] rd_data,
	input  wire logic                       m_tready,
	output logic                            m_tvalid,
	output logic      [tbs_pkg::WORD_W-1:0] m_tdata,
	output logic                            m_tlast,
	output logic                            space
);

	logic                       valid_s1;
	logic                       last_s1;
	logic                       m_valid_q;
	logic [tbs_pkg::WORD_W-1:0] m_data_q;
	logic                       m_last_q;
	logic                       adv;

	// read data stays in the buffer's output register until it moves on
	assign adv   = valid_s1 && (!m_valid_q || m_tready);
	assign space = !valid_s1 || adv;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			last_s1   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (rd_req.en) begin
				valid_s1 <= 1'b1;
				last_s1  <= rd_req.last;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_data_q <= rd_data;
			m_last_q <= last_s1;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/tbs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tbs_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       cfg_we,
	input wire logic                       s_tvalid,
	input wire logic                       s_tready,
	input wire logic                       m_tvalid,
	input wire logic                       m_tready,
	input wire logic [tbs_pkg::WORD_W-1:0] m_tdata,
	input wire logic                       m_tlast
);

	// a stalled output stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output dropped while stalled");

	// a stalled output keeps its word and flag
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	// the cycle after a register write no transfer is taken
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_tready)
		else $error("input taken during fill position rebuild");

	// a fresh output word comes from an earlier accepted input transfer
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("output appeared without a matching input transfer");

endmodule

bind texture_block_swizzle_unit tbs_checker u_tbs_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.cfg_we  (cfg_we),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

	// buffer geometry as the block is built here (default parameters)
	localparam int ROW_PITCH = tbs_pkg::MAX_ROW_BYTES_DEF / 4;
	localparam int HALF_SIZE = tbs_pkg::BAND_ROWS * ROW_PITCH;
	localparam int SETTLE    = 6;     // margin for the output pipeline to drain
	localparam int HOLD_LEN  = 400;   // long receiver hold-off

	typedef struct packed {
		logic                       op;
		logic [tbs_pkg::WORD_W-1:0] word;
	} linear_item_t;

	typedef struct packed {
		logic [tbs_pkg::WORD_W-1:0] word;
		logic                       last;
	} swizzled_t;

	// clock, reset and block inputs, all known from time zero
	logic                              clk       = 1'b0;
	logic                              arst_n    = 1'b0;
	logic                              cfg_we    = 1'b0;
	logic [tbs_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
	logic [tbs_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;
	logic                              s_tvalid  = 1'b0;
	logic [tbs_pkg::WORD_W-1:0]        s_tdata   = '0;
	logic                              s_tuser   = tbs_pkg::OP_DATA;
	logic                              m_tready  = 1'b0;
	wire logic                         s_tready;
	wire logic                         m_tvalid;
	wire logic [tbs_pkg::WORD_W-1:0]   m_tdata;
	wire logic                         m_tlast;

	// stimulus control
	linear_item_t linear_items[$];
	int           items_queued   = 0;
	int           src_idle_pct   = 0;
	int           sink_stall_pct = 0;
	logic         sink_hold      = 1'b0;
	event         start_hold;
	linear_item_t next_item;

	// checking
	swizzled_t owed_words[$];
	swizzled_t next_owed;
	int        mismatches = 0;

	// predictor state, mirrors the block after reset
	logic [tbs_pkg::ROW_BYTES_W-1:0] row_bytes_reg  = tbs_pkg::ROW_BYTES_RST;
	logic [tbs_pkg::BAND_CNT_W-1:0]  band_count_reg = tbs_pkg::BAND_COUNT_RST;
	logic [tbs_pkg::WORD_W-1:0]      band_mem [2*HALF_SIZE];
	int unsigned                     fill_pos   = 0;
	int unsigned                     emit_pos   = 0;
	int unsigned                     bands_done = 0;
	int unsigned                     bands_out  = 0;
	bit                              fill_side  = 1'b0;
	bit                              band_ready = 1'b0;

	texture_block_swizzle_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- geometry

	// row length in bytes after clamping to one block .. the widest row
	function automatic int clamped_row(logic [tbs_pkg::ROW_BYTES_W-1:0] rb);
		int v;
		v = int'(rb);
		if (v < tbs_pkg::BLOCK_BYTES) v = tbs_pkg::BLOCK_BYTES;
		if (v > tbs_pkg::MAX_ROW_BYTES_DEF) v = tbs_pkg::MAX_ROW_BYTES_DEF;
		return v;
	endfunction

	// words that arrive per row, tail included
	function automatic int row_words(logic [tbs_pkg::ROW_BYTES_W-1:0] rb);
		return clamped_row(rb) / 4;
	endfunction

	// words per row that land in whole blocks
	function automatic int kept_words(logic [tbs_pkg::ROW_BYTES_W-1:0] rb);
		return (clamped_row(rb) / tbs_pkg::BLOCK_BYTES) * tbs_pkg::BLOCK_WORDS;
	endfunction

	// ---------------------------------------------------------------- predictor

	// one accepted input transfer: emit at most one word of the pending band,
	// then store a data word into the filling half
	task automatic predict_swizzle(logic op, logic [tbs_pkg::WORD_W-1:0] word);
		int        wpr, used, band_words, emit_words, bands;
		int        blk, blk_pos, row, col, addr;
		bit        band_end;
		swizzled_t res;
		wpr        = row_words(row_bytes_reg);
		used       = kept_words(row_bytes_reg);
		band_words = tbs_pkg::BAND_ROWS * wpr;
		emit_words = tbs_pkg::BAND_ROWS * used;
		bands      = (int'(band_count_reg) > tbs_pkg::MAX_BANDS_DEF)
		           ? tbs_pkg::MAX_BANDS_DEF : int'(band_count_reg);

		if (band_ready) begin
			// block by block, each block top to bottom, four words per row
			blk      = emit_pos / (tbs_pkg::BAND_ROWS * tbs_pkg::BLOCK_WORDS);
			blk_pos  = emit_pos % (tbs_pkg::BAND_ROWS * tbs_pkg::BLOCK_WORDS);
			row      = blk_pos / tbs_pkg::BLOCK_WORDS;
			col      = blk * tbs_pkg::BLOCK_WORDS + blk_pos % tbs_pkg::BLOCK_WORDS;
			addr     = (fill_side ? 0 : HALF_SIZE) + (row % tbs_pkg::BAND_ROWS) * ROW_PITCH
			         + col % ROW_PITCH;
			band_end = (emit_pos + 1 >= emit_words);
			res.word = band_mem[addr % (2 * HALF_SIZE)];
			res.last = band_end && (bands_out + 1 >= bands);
			owed_words.insert(owed_words.size(), res);
			if (band_end) begin
				band_ready = 1'b0;
				emit_pos   = 0;
				if (bands_out < int'(tbs_pkg::BAND_CNT_SAT)) bands_out++;
			end else begin
				emit_pos++;
			end
		end

		if (op == tbs_pkg::OP_DATA && bands_done < bands) begin
			if (fill_pos < band_words) begin
				row = fill_pos / wpr;
				col = fill_pos % wpr;
				// words past the last whole block of a row are dropped
				if (col < used)
					band_mem[(fill_side ? HALF_SIZE : 0) + (row % tbs_pkg::BAND_ROWS) * ROW_PITCH
					         + col % ROW_PITCH] = word;
			end
			fill_pos++;
			if (fill_pos >= band_words) begin
				// band complete: swap halves, any older pending band is dropped
				fill_pos   = 0;
				fill_side  = ~fill_side;
				band_ready = 1'b1;
				emit_pos   = 0;
				bands_done++;
			end
		end
	endtask

	// ---------------------------------------------------------------- driver

	// input side: predict on every transfer, then offer the next item or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				predict_swizzle(s_tuser, s_tdata);
			if (!s_tvalid || s_tready) begin
				if (linear_items.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					next_item = linear_items.pop_front();
					s_tvalid  <= 1'b1;
					s_tdata   <= next_item.word;
					s_tuser   <= next_item.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= !sink_hold && ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// long hold-off, counted here so the generator can keep feeding items
	initial begin
		forever begin
			@(start_hold);
			sink_hold <= 1'b1;
			repeat (HOLD_LEN) @(posedge clk);
			sink_hold <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- monitor

	task automatic report_mismatch(string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// every output transfer is matched against the oldest owed word
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (owed_words.size() == 0) begin
				report_mismatch($sformatf("word %h last %b with nothing owed", m_tdata, m_tlast));
			end else begin
				next_owed = owed_words.pop_front();
				if (m_tdata !== next_owed.word)
					report_mismatch($sformatf("out_word %h, predicted %h",
					                          m_tdata, next_owed.word));
				if (m_tlast !== next_owed.last)
					report_mismatch($sformatf("last_word %b, predicted %b on word %h",
					                          m_tlast, next_owed.last, next_owed.word));
			end
		end
	end

	// ---------------------------------------------------------------- stimulus helpers

	task automatic push_item(logic op, logic [tbs_pkg::WORD_W-1:0] word);
		linear_item_t entry;
		entry.op   = op;
		entry.word = word;
		linear_items.insert(linear_items.size(), entry);
		items_queued++;
	endtask

	// texel words, mostly random with some corner patterns
	function automatic logic [tbs_pkg::WORD_W-1:0] texel_word();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return 32'h1 << $urandom_range(0, 31);
			3:       return ~(32'h1 << $urandom_range(0, 31));
			default: return $urandom;
		endcase
	endfunction

	// data words with the odd drain mixed in
	task automatic queue_data(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) push_item(tbs_pkg::OP_DRAIN, $urandom);
			push_item(tbs_pkg::OP_DATA, texel_word());
		end
	endtask

	// flush the final band; data words are only mixed in once the image is full
	task automatic queue_flush(int n, bit mixed);
		for (int i = 0; i < n; i++)
			push_item((mixed && $urandom_range(0, 3) == 0) ? tbs_pkg::OP_DATA : tbs_pkg::OP_DRAIN,
			          $urandom);
	endtask

	// nothing left to send and nothing owed, then let the pipeline settle
	task automatic wait_quiet();
		while (linear_items.size() != 0 || s_tvalid || owed_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// the task idles after each write so the enable stays a clean pulse
	task automatic write_reg(logic [tbs_pkg::CFG_IDX_W-1:0] idx,
	                         logic [tbs_pkg::CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == tbs_pkg::CFG_ROW_BYTES)
			row_bytes_reg = value[tbs_pkg::ROW_BYTES_W-1:0];
		else
			band_count_reg = value[tbs_pkg::BAND_CNT_W-1:0];
		@(posedge clk);
	endtask

	task automatic set_idling(int mode);
		case (mode % 4)
			0: begin src_idle_pct <= 0;  sink_stall_pct <= 0;  end
			1: begin src_idle_pct <= 55; sink_stall_pct <= 0;  end
			2: begin src_idle_pct <= 0;  sink_stall_pct <= 55; end
			default: begin src_idle_pct <= 33; sink_stall_pct <= 33; end
		endcase
	endtask

	// new image geometry: n_bands more bands on top of those already filled,
	// upper bits of the band count write carry junk that the block must ignore
	task automatic start_phase(logic [tbs_pkg::ROW_BYTES_W-1:0] rb, int n_bands, int mode);
		logic [tbs_pkg::BAND_CNT_W-1:0]                     bc;
		logic [tbs_pkg::CFG_DATA_W-tbs_pkg::BAND_CNT_W-1:0] junk;
		wait_quiet();
		bc   = tbs_pkg::BAND_CNT_W'(bands_done + n_bands);
		junk = (tbs_pkg::CFG_DATA_W - tbs_pkg::BAND_CNT_W)'($urandom);
		write_reg(tbs_pkg::CFG_ROW_BYTES, rb);
		write_reg(tbs_pkg::CFG_BAND_COUNT, {junk, bc});
		set_idling(mode);
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		logic [tbs_pkg::ROW_BYTES_W-1:0] rb;
		int                              n, total, cut, phase_no;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// single band image, row below one block clamps up to 16 bytes
		start_phase(12'd5, 1, 0);
		push_item(tbs_pkg::OP_DRAIN, '1);                // drain with nothing pending
		push_item(tbs_pkg::OP_DATA, '0);
		push_item(tbs_pkg::OP_DATA, '1);
		push_item(tbs_pkg::OP_DATA, 32'h5555_5555);
		push_item(tbs_pkg::OP_DATA, 32'hAAAA_AAAA);
		for (int i = 0; i < 28; i++) begin
			if (i == 12) push_item(tbs_pkg::OP_DRAIN, '0); // drain inside a partial band
			push_item(tbs_pkg::OP_DATA, 32'h1 << i);
		end
		queue_flush(tbs_pkg::BAND_ROWS * kept_words(12'd5) + 3, 1'b1);

		// row with a tail past the last block; sender pauses mid band
		start_phase(12'd40, 3, 1);
		total = 3 * tbs_pkg::BAND_ROWS * row_words(12'd40);
		queue_data(total / 2);
		wait_quiet();
		queue_data(total - total / 2);
		queue_flush(tbs_pkg::BAND_ROWS * kept_words(12'd40) + 3, 1'b1);

		// zero band count: everything ignored, widest row clamps down
		wait_quiet();
		write_reg(tbs_pkg::CFG_ROW_BYTES, 12'hFFF);
		write_reg(tbs_pkg::CFG_BAND_COUNT, 12'hF80);
		set_idling(2);
		queue_flush(20, 1'b1);

		// low row length bits ignored; receiver holds off once output is flowing
		start_phase(12'd66, 3, 3);
		total = tbs_pkg::BAND_ROWS * row_words(12'd66);
		queue_data(total);
		wait_quiet();
		-> start_hold;
		queue_data(2 * total);
		queue_flush(tbs_pkg::BAND_ROWS * kept_words(12'd66) + 3, 1'b1);

		// narrowest rows, both halves turning over quickly
		start_phase(12'd16, 4, 0);
		queue_data(4 * tbs_pkg::BAND_ROWS * row_words(12'd16));
		queue_flush(tbs_pkg::BAND_ROWS * kept_words(12'd16) + 3, 1'b1);

		// row length shrinks under a partial band: the stale fill position
		// completes it at once and drops the rest of the pending band
		start_phase(12'd64, 3, 2);
		queue_data(2 * tbs_pkg::BAND_ROWS * row_words(12'd64) + 50);
		wait_quiet();
		write_reg(tbs_pkg::CFG_ROW_BYTES, 12'd16);
		queue_data(1);
		queue_flush(tbs_pkg::BAND_ROWS * kept_words(12'd16) + 3, 1'b1);

		// random geometries, whole bands, sometimes a pause mid image
		phase_no = 0;
		while (items_queued < 1600 && bands_done + 2 < tbs_pkg::MAX_BANDS_DEF - 4) begin
			rb    = tbs_pkg::ROW_BYTES_W'(($urandom_range(0, 5) == 0)
			        ? $urandom_range(0, 15) : $urandom_range(16, 80));
			n     = $urandom_range(1, 2);
			start_phase(rb, n, phase_no);
			total = n * tbs_pkg::BAND_ROWS * row_words(rb);
			if ($urandom_range(0, 3) == 0) begin
				cut = $urandom_range(1, total - 1);
				queue_data(cut);
				wait_quiet();
				queue_data(total - cut);
			end else begin
				queue_data(total);
			end
			queue_flush(tbs_pkg::BAND_ROWS * kept_words(rb) + 3, 1'b1);
			phase_no++;
		end

		// band count saturates, so the final band is never flagged as last
		wait_quiet();
		rb = tbs_pkg::ROW_BYTES_W'($urandom_range(16, 48));
		write_reg(tbs_pkg::CFG_ROW_BYTES, rb);
		write_reg(tbs_pkg::CFG_BAND_COUNT, 12'd127);
		set_idling(1);
		queue_data(tbs_pkg::BAND_ROWS * row_words(rb));
		queue_flush(tbs_pkg::BAND_ROWS * kept_words(rb) + 3, 1'b0);

		wait_quiet();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && owed_words.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/core/tbs_pkg.sv
rtl/core/tbs_buffer.sv
rtl/core/tbs_fill.sv
rtl/core/tbs_emit.sv
rtl/core/tbs_out.sv
rtl/core/texture_block_swizzle_unit.sv
rtl/core/tbs_checker.sv
tb/tb.sv
